@@ hdl/rhe_pkg.sv @@
// Shared constants and types of the RGB histogram equalizer.
// Used by rhe_div and rgb_histogram_equalizer; depends on nothing else.
`timescale 1ns / 1ps
package rhe_pkg;

  localparam int unsigned LEVEL_BITS = 8;
  localparam int unsigned LEVELS     = 1 << LEVEL_BITS;
  localparam int unsigned NCH        = 3;
  localparam int unsigned MAX_PIXELS = 1048576;

  // bin and pixel counters hold 0 .. MAX_PIXELS
  localparam int unsigned CNT_W  = $clog2(MAX_PIXELS + 1);
  // cumulative count over all levels of one channel
  localparam int unsigned CUM_W  = CNT_W + LEVEL_BITS;
  // LEVEL_MAX times the cumulative count
  localparam int unsigned PROD_W = CUM_W + LEVEL_BITS;
  // divider step counter: one preload step plus one step per quotient bit
  localparam int unsigned DCNT_W = $clog2(LEVEL_BITS + 2);

  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};
  localparam logic [CNT_W-1:0]      CNT_MAX   = CNT_W'(MAX_PIXELS);

  typedef logic [LEVEL_BITS-1:0] level_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CUM_W-1:0]      cum_t;

  // saturating increment of a counter
  function automatic cnt_t sat_inc(input cnt_t v);
    cnt_t r;
    if (v >= CNT_MAX) r = CNT_MAX;
    else              r = v + cnt_t'(1);
    return r;
  endfunction

endpackage

@@ hdl/rhe_div.sv @@
// Bit-serial divider: floor(LEVEL_MAX * cum / total), clamped to LEVEL_MAX.
// Depends on rhe_pkg.
`timescale 1ns / 1ps
module rhe_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rhe_pkg::cum_t     cum_i,
  input  rhe_pkg::cnt_t     total_i,
  output logic              done_o,
  output rhe_pkg::level_t   q_o
);

  logic [rhe_pkg::PROD_W-1:0]     n_q;
  logic [rhe_pkg::LEVEL_BITS-1:0] low_q;
  rhe_pkg::cnt_t                  r_q;
  rhe_pkg::level_t                q_q;
  logic                           clamp_q;
  logic [rhe_pkg::DCNT_W-1:0]     cnt_q;
  logic                           done_q;

  logic [rhe_pkg::CNT_W:0]        r2;
  logic                           ge;

  // one restoring step: shift in next numerator bit, trial subtract
  assign r2 = {r_q, low_q[rhe_pkg::LEVEL_BITS-1]};
  assign ge = (r2 >= {1'b0, total_i});

  // control: step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (load_i) begin
        cnt_q <= rhe_pkg::DCNT_W'(rhe_pkg::LEVEL_BITS + 1);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == rhe_pkg::DCNT_W'(1)) done_q <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      // 255 * cum as (cum << 8) - cum; a quotient >= LEVEL_MAX when cum >= total
      n_q     <= ({cum_i, {rhe_pkg::LEVEL_BITS{1'b0}}}) - rhe_pkg::PROD_W'(cum_i);
      clamp_q <= (cum_i >= rhe_pkg::CUM_W'(total_i));
      q_q     <= '0;
    end else if (cnt_q == rhe_pkg::DCNT_W'(rhe_pkg::LEVEL_BITS + 1)) begin
      // high part of numerator is below total when not clamped
      r_q   <= rhe_pkg::CNT_W'(n_q >> rhe_pkg::LEVEL_BITS);
      low_q <= n_q[rhe_pkg::LEVEL_BITS-1:0];
    end else if (cnt_q != '0) begin
      r_q   <= ge ? rhe_pkg::CNT_W'(r2 - {1'b0, total_i}) : rhe_pkg::CNT_W'(r2);
      q_q   <= {q_q[rhe_pkg::LEVEL_BITS-2:0], ge};
      low_q <= low_q << 1;
    end
  end

  assign done_o = done_q;
  assign q_o    = clamp_q ? rhe_pkg::LEVEL_MAX : q_q;

endmodule

@@ hdl/rgb_histogram_equalizer.sv @@
// Top level of the RGB histogram equalizer: histogram and mapping memories,
// accumulate / table build sequencer. Depends on rhe_pkg and rhe_div.
`timescale 1ns / 1ps
// Usage
//   A transaction is taken when start is high and busy low. mode_i = 0
//   adds the pixel to the red, green and blue histograms; with last_i high
//   the three mapping tables are then built and the histograms cleared.
//   mode_i = 1 looks the pixel up in the tables: the mapped levels appear on
//   mapped_*_o with result_valid_o high for exactly one cycle, the cycle
//   after acceptance. The receiver cannot stall; results are not held.
// Throughput
//   Map pixel: busy stays low, one per cycle.
//   Accumulate pixel: read-modify-write of the bin memories (read, then
//   write back the incremented count); busy is high for the write-back.
//   Table build: for each of the 256 levels a bin read, sum and load, the
//   bit-serial divider (one preload step, eight quotient bits) and the
//   table write; busy is high throughout.
// Reset
//   After reset a clearing pass zeroes the bin and mapping memories, one
//   row a cycle; busy is high while it runs.
module rgb_histogram_equalizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       mode_i,
  input  logic [7:0] pixel_red_i,
  input  logic [7:0] pixel_green_i,
  input  logic [7:0] pixel_blue_i,
  input  logic       last_i,
  output logic       result_valid_o,
  output logic [7:0] mapped_red_o,
  output logic [7:0] mapped_green_o,
  output logic [7:0] mapped_blue_o
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_ACC, ST_BRD, ST_BACC, ST_BLOAD, ST_BDIV
  } state_e;

  state_e                state_q;
  rhe_pkg::level_t       lvl_q;
  rhe_pkg::cnt_t         pixels_q;
  rhe_pkg::cnt_t         total_q;
  logic                  last_q;
  logic                  valid_q;
  rhe_pkg::level_t       acc_addr_q [rhe_pkg::NCH];
  rhe_pkg::cum_t         cum_q      [rhe_pkg::NCH];

  // memories, one bank per channel
  rhe_pkg::cnt_t         bin_mem [rhe_pkg::NCH][rhe_pkg::LEVELS];
  rhe_pkg::level_t       map_mem [rhe_pkg::NCH][rhe_pkg::LEVELS];
  rhe_pkg::cnt_t         bin_rd_q [rhe_pkg::NCH];
  rhe_pkg::level_t       map_rd_q [rhe_pkg::NCH];

  logic                  accept;
  logic                  acc_accept;
  logic                  map_accept;
  rhe_pkg::level_t       pix_lvl [rhe_pkg::NCH];

  logic                  bin_we, bin_re, map_we;
  rhe_pkg::level_t       bin_waddr [rhe_pkg::NCH];
  rhe_pkg::level_t       bin_raddr [rhe_pkg::NCH];
  rhe_pkg::cnt_t         bin_wdata [rhe_pkg::NCH];
  rhe_pkg::level_t       map_wdata [rhe_pkg::NCH];

  logic                      div_load;
  logic [rhe_pkg::NCH-1:0]   div_done;
  rhe_pkg::level_t           div_q   [rhe_pkg::NCH];

  assign busy       = (state_q != ST_IDLE);
  assign accept     = start && !busy;
  assign acc_accept = accept && !mode_i;
  assign map_accept = accept && mode_i;

  assign pix_lvl[0] = pixel_red_i[rhe_pkg::LEVEL_BITS-1:0];
  assign pix_lvl[1] = pixel_green_i[rhe_pkg::LEVEL_BITS-1:0];
  assign pix_lvl[2] = pixel_blue_i[rhe_pkg::LEVEL_BITS-1:0];

  // memory port control
  always_comb begin
    bin_we = (state_q == ST_CLEAR) || (state_q == ST_ACC) || (state_q == ST_BRD);
    bin_re = acc_accept || (state_q == ST_BRD);
    map_we = (state_q == ST_CLEAR) || ((state_q == ST_BDIV) && (&div_done));
    for (int c = 0; c < rhe_pkg::NCH; c++) begin
      bin_waddr[c] = (state_q == ST_ACC) ? acc_addr_q[c] : lvl_q;
      bin_raddr[c] = (state_q == ST_BRD) ? lvl_q : pix_lvl[c];
      bin_wdata[c] = (state_q == ST_ACC) ? rhe_pkg::sat_inc(bin_rd_q[c]) : '0;
      map_wdata[c] = (state_q == ST_CLEAR) ? '0 : div_q[c];
    end
  end

  // bin memories: read-first, so a build read sees the count it clears
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < rhe_pkg::NCH; c++) begin
      if (bin_we) bin_mem[c][bin_waddr[c]] <= bin_wdata[c];
      if (bin_re) bin_rd_q[c] <= bin_mem[c][bin_raddr[c]];
    end
  end

  // mapping memories
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < rhe_pkg::NCH; c++) begin
      if (map_we)     map_mem[c][lvl_q] <= map_wdata[c];
      if (map_accept) map_rd_q[c] <= map_mem[c][pix_lvl[c]];
    end
  end

  // one divider per channel
  assign div_load = (state_q == ST_BLOAD);

  for (genvar g = 0; g < rhe_pkg::NCH; g++) begin : g_div
    rhe_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (div_load),
      .cum_i   (cum_q[g]),
      .total_i (total_q),
      .done_o  (div_done[g]),
      .q_o     (div_q[g])
    );
  end

  // sequencer: clearing pass, accumulate write-back, table build
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      lvl_q    <= '0;
      pixels_q <= '0;
      total_q  <= '0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= map_accept;
      case (state_q)
        ST_CLEAR: begin
          lvl_q <= lvl_q + 1'b1;
          if (lvl_q == rhe_pkg::LEVEL_MAX) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (acc_accept) state_q <= ST_ACC;
        end
        ST_ACC: begin
          if (last_q) begin
            total_q  <= rhe_pkg::sat_inc(pixels_q);
            pixels_q <= '0;
            lvl_q    <= '0;
            state_q  <= ST_BRD;
          end else begin
            pixels_q <= rhe_pkg::sat_inc(pixels_q);
            state_q  <= ST_IDLE;
          end
        end
        ST_BRD:   state_q <= ST_BACC;
        ST_BACC:  state_q <= ST_BLOAD;
        ST_BLOAD: state_q <= ST_BDIV;
        ST_BDIV: begin
          if (&div_done) begin
            lvl_q <= lvl_q + 1'b1;
            if (lvl_q == rhe_pkg::LEVEL_MAX) state_q <= ST_IDLE;
            else                             state_q <= ST_BRD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers of the accumulate transaction and running sums
  always_ff @(posedge clk_i) begin
    if (acc_accept) begin
      last_q <= last_i;
      for (int c = 0; c < rhe_pkg::NCH; c++) acc_addr_q[c] <= pix_lvl[c];
    end
    for (int c = 0; c < rhe_pkg::NCH; c++) begin
      if ((state_q == ST_ACC) && last_q) cum_q[c] <= '0;
      else if (state_q == ST_BACC)       cum_q[c] <= cum_q[c] + rhe_pkg::CUM_W'(bin_rd_q[c]);
    end
  end

  assign result_valid_o = valid_q;
  assign mapped_red_o   = 8'(map_rd_q[0]);
  assign mapped_green_o = 8'(map_rd_q[1]);
  assign mapped_blue_o  = 8'(map_rd_q[2]);

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of rgb_histogram_equalizer: frames of accumulate pixels
// build the tables, then map pixels are checked against an in-bench predictor.
// Depends on rhe_pkg and the RTL of rgb_histogram_equalizer.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned NCH        = rhe_pkg::NCH;
  localparam int unsigned LEVELS     = rhe_pkg::LEVELS;
  localparam int unsigned MAX_PIXELS = rhe_pkg::MAX_PIXELS;
  localparam logic [7:0]  LEVEL_MAX  = rhe_pkg::LEVEL_MAX;

  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam logic        MODE_ACC = 1'b0;
  localparam logic        MODE_MAP = 1'b1;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic       mode_i;
  logic [7:0] pixel_red_i;
  logic [7:0] pixel_green_i;
  logic [7:0] pixel_blue_i;
  logic       last_i;
  logic       result_valid_o;
  logic [7:0] mapped_red_o;
  logic [7:0] mapped_green_o;
  logic [7:0] mapped_blue_o;

  // predictor state
  longint unsigned hist_bins[NCH][LEVELS];
  logic [7:0]      eq_table[NCH][LEVELS];
  longint unsigned frame_pixels;

  rgb_t        mapped_pending[$];
  int unsigned mismatches;
  int unsigned pixels_checked;
  int unsigned tables_built;
  int unsigned items_sent;
  int unsigned quiet_cycles;
  bit          gaps_on;

  rgb_histogram_equalizer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .pixel_red_i    (pixel_red_i),
    .pixel_green_i  (pixel_green_i),
    .pixel_blue_i   (pixel_blue_i),
    .last_i         (last_i),
    .result_valid_o (result_valid_o),
    .mapped_red_o   (mapped_red_o),
    .mapped_green_o (mapped_green_o),
    .mapped_blue_o  (mapped_blue_o)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned count_inc(input longint unsigned v);
    return (v >= MAX_PIXELS) ? longint'(MAX_PIXELS) : v + 1;
  endfunction

  // cumulative histogram to equalisation table, histograms cleared afterwards
  function automatic void build_eq_tables();
    longint unsigned total;
    longint unsigned cum;
    longint unsigned q;
    total = (frame_pixels == 0) ? 1 : frame_pixels;
    for (int c = 0; c < NCH; c++) begin
      cum = 0;
      for (int v = 0; v < LEVELS; v++) begin
        cum += hist_bins[c][v];
        q = (longint'(LEVEL_MAX) * cum) / total;
        if (q > LEVEL_MAX) q = LEVEL_MAX;
        eq_table[c][v] = q[7:0];
        hist_bins[c][v] = 0;
      end
    end
    frame_pixels = 0;
    tables_built++;
  endfunction

  // apply one accepted transaction to the predictor
  function automatic void predict_pixel(input logic m, input rgb_t px, input logic lst);
    rgb_t r;
    if (m == MODE_ACC) begin
      hist_bins[0][px.red]   = count_inc(hist_bins[0][px.red]);
      hist_bins[1][px.green] = count_inc(hist_bins[1][px.green]);
      hist_bins[2][px.blue]  = count_inc(hist_bins[2][px.blue]);
      frame_pixels = count_inc(frame_pixels);
      if (lst) build_eq_tables();
    end else begin
      r.red   = eq_table[0][px.red];
      r.green = eq_table[1][px.green];
      r.blue  = eq_table[2][px.blue];
      mapped_pending.push_back(r);
    end
  endfunction

  // drive one pixel and hold it until taken
  task automatic send_pixel(input logic m, input rgb_t px, input logic lst);
    @(negedge clk_i);
    start         <= 1'b1;
    mode_i        <= m;
    pixel_red_i   <= px.red;
    pixel_green_i <= px.green;
    pixel_blue_i  <= px.blue;
    last_i        <= lst;
    do @(posedge clk_i); while (busy);
    predict_pixel(m, px, lst);
    items_sent++;
  endtask

  task automatic idle_cycles(input int unsigned n);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // random sender gap between transactions
  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 19));
  endtask

  function automatic rgb_t rand_rgb();
    rgb_t p;
    p.red   = 8'($urandom_range(0, 255));
    p.green = 8'($urandom_range(0, 255));
    p.blue  = 8'($urandom_range(0, 255));
    return p;
  endfunction

  function automatic rgb_t mk_rgb(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b);
    rgb_t p;
    p.red = r; p.green = g; p.blue = b;
    return p;
  endfunction

  // tables are all zero until the first build; last is ignored when mapping
  task automatic test_map_before_build();
    send_pixel(MODE_MAP, mk_rgb(8'h00, 8'h00, 8'h00), 1'b0);
    send_pixel(MODE_MAP, mk_rgb(8'hff, 8'hff, 8'hff), 1'b1);
    send_pixel(MODE_MAP, mk_rgb(8'h55, 8'haa, 8'h0f), 1'b0);
  endtask

  // single pixel frame at the level extremes and mid-scale, then lookups on both sides
  task automatic test_single_pixel_frame();
    send_pixel(MODE_ACC, mk_rgb(8'h00, 8'hff, 8'h80), 1'b1);
    send_pixel(MODE_MAP, mk_rgb(8'h00, 8'h00, 8'h00), 1'b0);
    send_pixel(MODE_MAP, mk_rgb(8'hff, 8'hfe, 8'h7f), 1'b0);
    send_pixel(MODE_MAP, mk_rgb(8'h01, 8'hff, 8'h80), 1'b1);
  endtask

  // uneven frame at the extremes; map pixels without last keep old tables
  task automatic test_extreme_frame();
    send_pixel(MODE_ACC, mk_rgb(8'hff, 8'h00, 8'h00), 1'b0);
    send_pixel(MODE_MAP, mk_rgb(8'hff, 8'h00, 8'h80), 1'b0);
    send_pixel(MODE_ACC, mk_rgb(8'hff, 8'h00, 8'hff), 1'b0);
    send_pixel(MODE_ACC, mk_rgb(8'h00, 8'hff, 8'h55), 1'b1);
    send_pixel(MODE_MAP, mk_rgb(8'h00, 8'h00, 8'h00), 1'b0);
    send_pixel(MODE_MAP, mk_rgb(8'hff, 8'hff, 8'hff), 1'b0);
    send_pixel(MODE_MAP, mk_rgb(8'hfe, 8'h01, 8'h55), 1'b0);
    send_pixel(MODE_MAP, mk_rgb(8'haa, 8'h55, 8'haa), 1'b1);
  endtask

  // frames with random content and size, map bursts, and some noise
  task automatic test_random_frames(input int unsigned n_items);
    int unsigned target;
    int unsigned frame_len;
    int unsigned map_len;
    rgb_t        px;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if (target - items_sent < 200) gaps_on = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        // noise: loose pixel of either kind, last at random
        send_pixel(1'($urandom_range(0, 1)), rand_rgb(), 1'($urandom_range(0, 1)));
        maybe_gap();
      end else begin
        frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 40);
        for (int unsigned i = 0; i < frame_len; i++) begin
          // narrow red spread in some pixels of long frames to give steep tables
          px = rand_rgb();
          if (frame_len > 20 && $urandom_range(0, 1)) px.red = 8'($urandom_range(100, 110));
          send_pixel(MODE_ACC, px, i == frame_len - 1);
          maybe_gap();
        end
        map_len = $urandom_range(5, 60);
        for (int unsigned i = 0; i < map_len; i++) begin
          send_pixel(MODE_MAP, rand_rgb(), 1'($urandom_range(0, 1)));
          maybe_gap();
        end
      end
    end
  endtask

  // compare each result with the oldest pending lookup
  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni && result_valid_o) begin
      if (mapped_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                   mapped_red_o, mapped_green_o, mapped_blue_o);
      end else begin
        want = mapped_pending.pop_front();
        pixels_checked++;
        if (mapped_red_o !== want.red || mapped_green_o !== want.green ||
            mapped_blue_o !== want.blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                     $time, want.red, want.green, want.blue,
                     mapped_red_o, mapped_green_o, mapped_blue_o);
        end
      end
    end
  end

  // watchdog on cycles with no transaction and no result
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    start = 1'b0; mode_i = MODE_ACC; last_i = 1'b0;
    pixel_red_i = '0; pixel_green_i = '0; pixel_blue_i = '0;
    rst_ni = 1'b0;
    mismatches = 0; pixels_checked = 0; tables_built = 0; items_sent = 0;
    quiet_cycles = 0; gaps_on = 1'b1; frame_pixels = 0;
    for (int c = 0; c < NCH; c++)
      for (int v = 0; v < LEVELS; v++) begin
        hist_bins[c][v] = 0;
        eq_table[c][v]  = '0;
      end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_map_before_build();
    test_single_pixel_frame();
    test_extreme_frame();
    test_random_frames(1000);

    idle_cycles(1);
    wait (mapped_pending.size() == 0);
    repeat (20) @(posedge clk_i);

    $display("%0d transactions sent, %0d tables built, %0d mapped pixels checked",
             items_sent, tables_built, pixels_checked);
    if (mismatches == 0 && mapped_pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, mapped_pending.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ rgb_histogram_equalizer.f @@
hdl/rhe_pkg.sv
hdl/rhe_div.sv
hdl/rgb_histogram_equalizer.sv
tb/tb_top.sv
